FILE: hdl/per_pixel_running_mean_defines.svh
// assertion macros for the per-pixel running mean block
// used by the port checker; expects clk and rst in scope
`ifndef PER_PIXEL_RUNNING_MEAN_DEFINES_SVH
`define PER_PIXEL_RUNNING_MEAN_DEFINES_SVH

// same-cycle implication
`define PPM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PPM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also holds across reset
`define PPM_ASSERT_RST(label, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/ppm_pkg.sv
// shared types and constants of the per-pixel running mean block
// no dependencies
`default_nettype none

package ppm_pkg;

  localparam int IDX_W      = 16;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 4;
  localparam int FRAC_BITS  = 8;
  localparam int MEAN_W     = CH_W + FRAC_BITS;
  localparam int COUNT_BITS = 16;
  localparam int CFG_W      = 17;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = 2;
  localparam int QCNT_W     = 3;
  localparam int DIV_STAGES = 8;

  localparam logic [CFG_W-1:0]      MAX_PIXELS = 17'h10000;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 16'hFFFF;

  // one classified item on its way from front to back
  typedef struct packed {
    logic [IDX_W-1:0]             idx;
    logic [NUM_CH-1:0][CH_W-1:0]  smp;
    logic [COUNT_BITS-1:0]        n;
    logic                         first;
    logic                         last;
    logic                         err;
  } item_t;

endpackage

`default_nettype wire

FILE: hdl/ppm_front.sv
// front part: accepts pixels, checks the index, tracks the frame counter
// depends on ppm_pkg
`default_nettype none

module ppm_front (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [ppm_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [47:0]                   s_axis_tdata,
  input  wire logic                          q_full,
  output logic                               push,
  output ppm_pkg::item_t                     push_item
);

  logic [ppm_pkg::CFG_W-1:0]      pixel_count;
  logic [ppm_pkg::COUNT_BITS-1:0] frame_counter;
  logic [ppm_pkg::CFG_W-1:0]      limit;
  logic [ppm_pkg::IDX_W-1:0]      idx;

  assign s_axis_tready = !q_full;
  assign push          = s_axis_tvalid && s_axis_tready;
  assign idx           = s_axis_tdata[15:0];
  assign limit = (pixel_count > ppm_pkg::MAX_PIXELS) ? ppm_pkg::MAX_PIXELS : pixel_count;

  always_comb begin
    push_item.idx   = idx;
    push_item.smp   = s_axis_tdata[47:16];
    push_item.err   = ({1'b0, idx} >= limit);
    push_item.last  = !push_item.err && ({1'b0, idx} == limit - 17'd1);
    push_item.first = (frame_counter == '0);
    push_item.n     = (frame_counter == ppm_pkg::COUNT_MAX) ? ppm_pkg::COUNT_MAX
                                                            : frame_counter + 16'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_count   <= ppm_pkg::MAX_PIXELS;
      frame_counter <= '0;
    end else begin
      if (cfg_we) begin
        pixel_count <= cfg_data;
      end
      if (push && push_item.last && frame_counter != ppm_pkg::COUNT_MAX) begin
        frame_counter <= frame_counter + 16'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ppm_queue.sv
// short item queue between front and back
// depends on ppm_pkg
`default_nettype none

module ppm_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire ppm_pkg::item_t push_item,
  input  wire logic           pop,
  output logic                full,
  output logic                head_valid,
  output ppm_pkg::item_t      head_item
);

  ppm_pkg::item_t                 slots [ppm_pkg::QDEPTH];
  logic [ppm_pkg::QPTR_W-1:0]     wr_ptr;
  logic [ppm_pkg::QPTR_W-1:0]     rd_ptr;
  logic [ppm_pkg::QCNT_W-1:0]     count;

  assign full       = (count == ppm_pkg::QCNT_W'(ppm_pkg::QDEPTH));
  assign head_valid = (count != '0);
  assign head_item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/ppm_back.sv
// back part: mean store, pipelined divide of the correction, result register
// depends on ppm_pkg
`default_nettype none

module ppm_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           head_valid,
  input  wire ppm_pkg::item_t head_item,
  output logic                pop,
  output logic                m_axis_tvalid,
  input  wire logic           m_axis_tready,
  output logic [63:0]         m_axis_tdata,
  output logic                m_axis_tlast,
  output logic                m_axis_tuser
);

  localparam int NS = ppm_pkg::DIV_STAGES;
  localparam int MW = ppm_pkg::MEAN_W;

  typedef logic [MW-1:0] mean_t;

  // one restoring divide step: shifts one quotient bit into dvd
  function automatic logic [2*MW-1:0] div_step(input mean_t rem, input mean_t dvd,
                                               input mean_t den);
    logic [MW:0]  r;
    mean_t        d;
    r = {rem, dvd[MW-1]};
    d = {dvd[MW-2:0], 1'b0};
    if (r >= {1'b0, den}) begin
      r    = r - {1'b0, den};
      d[0] = 1'b1;
    end
    return {r[MW-1:0], d};
  endfunction

  logic [ppm_pkg::NUM_CH*MW-1:0] mem [2**ppm_pkg::IDX_W];

  logic                           adv;
  logic                           hazard;
  logic                           s0_valid;
  ppm_pkg::item_t                 s0_item;
  logic [ppm_pkg::NUM_CH*MW-1:0]  rd_data;

  logic           d_valid [NS+1];
  ppm_pkg::item_t d_item  [NS+1];
  mean_t          d_mean  [NS+1][ppm_pkg::NUM_CH];
  logic           d_neg   [NS+1][ppm_pkg::NUM_CH];
  mean_t          d_rem   [NS+1][ppm_pkg::NUM_CH];
  mean_t          d_dvd   [NS+1][ppm_pkg::NUM_CH];

  mean_t          new_mean [ppm_pkg::NUM_CH];

  assign adv = !m_axis_tvalid || m_axis_tready;

  // an item must not read an entry that an older item is still updating
  always_comb begin
    hazard = s0_valid && !s0_item.err && (s0_item.idx == head_item.idx);
    for (int k = 0; k <= NS; k++) begin
      if (d_valid[k] && !d_item[k].err && d_item[k].idx == head_item.idx) hazard = 1'b1;
    end
    if (head_item.err) hazard = 1'b0;
  end

  assign pop = head_valid && !hazard && adv;

  always_ff @(posedge clk) begin
    if (pop) begin
      rd_data <= mem[head_item.idx];
    end
    if (adv && d_valid[NS] && !d_item[NS].err) begin
      mem[d_item[NS].idx] <= {new_mean[3], new_mean[2], new_mean[1], new_mean[0]};
    end
  end

  always_comb begin
    for (int c = 0; c < ppm_pkg::NUM_CH; c++) begin
      if (d_item[NS].first) begin
        new_mean[c] = {d_item[NS].smp[c], ppm_pkg::FRAC_BITS'(0)};
      end else if (d_neg[NS][c]) begin
        new_mean[c] = d_mean[NS][c] - d_dvd[NS][c];
      end else begin
        new_mean[c] = d_mean[NS][c] + d_dvd[NS][c];
      end
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    logic [MW:0]        diff;
    mean_t              tgt;
    mean_t              m;
    logic [2*MW-1:0]    s1;
    logic [2*MW-1:0]    s2;
    if (adv) begin
      s0_item <= head_item;
      d_item[0] <= s0_item;
      for (int c = 0; c < ppm_pkg::NUM_CH; c++) begin
        tgt  = {s0_item.smp[c], ppm_pkg::FRAC_BITS'(0)};
        m    = rd_data[c*MW +: MW];
        diff = {1'b0, tgt} - {1'b0, m};
        d_mean[0][c] <= m;
        d_neg[0][c]  <= diff[MW];
        d_rem[0][c]  <= '0;
        d_dvd[0][c]  <= diff[MW] ? (~diff[MW-1:0] + 1'b1) : diff[MW-1:0];
      end
      for (int k = 0; k < NS; k++) begin
        d_item[k+1] <= d_item[k];
        for (int c = 0; c < ppm_pkg::NUM_CH; c++) begin
          s1 = div_step(d_rem[k][c], d_dvd[k][c], d_item[k].n);
          s2 = div_step(s1[2*MW-1:MW], s1[MW-1:0], d_item[k].n);
          d_mean[k+1][c] <= d_mean[k][c];
          d_neg[k+1][c]  <= d_neg[k][c];
          d_rem[k+1][c]  <= s2[2*MW-1:MW];
          d_dvd[k+1][c]  <= s2[MW-1:0];
        end
      end
      m_axis_tdata[15:0]  <= d_item[NS].idx;
      m_axis_tdata[23:16] <= d_item[NS].err ? 8'd0 : new_mean[0][MW-1:ppm_pkg::FRAC_BITS];
      m_axis_tdata[31:24] <= d_item[NS].err ? 8'd0 : new_mean[1][MW-1:ppm_pkg::FRAC_BITS];
      m_axis_tdata[39:32] <= d_item[NS].err ? 8'd0 : new_mean[2][MW-1:ppm_pkg::FRAC_BITS];
      m_axis_tdata[47:40] <= d_item[NS].err ? 8'd0 : new_mean[3][MW-1:ppm_pkg::FRAC_BITS];
      m_axis_tdata[63:48] <= d_item[NS].err ? 16'd0 : d_item[NS].n;
      m_axis_tlast        <= d_item[NS].last;
      m_axis_tuser        <= d_item[NS].err;
    end
  end

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
      for (int k = 0; k <= NS; k++) d_valid[k] <= 1'b0;
    end else if (adv) begin
      s0_valid   <= pop;
      d_valid[0] <= s0_valid;
      for (int k = 0; k < NS; k++) d_valid[k+1] <= d_valid[k];
      m_axis_tvalid <= d_valid[NS];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/per_pixel_running_mean.sv
// per-pixel temporal running mean over an rgba stream, top level
// depends on ppm_pkg, ppm_front, ppm_queue, ppm_back
// pipeline: item queue, store read register s0, divide registers d, result register
// throughput: one item per cycle while the result side is not stalled; an item
//   whose pixel is still being updated by an earlier item waits for that write,
//   a wait set by the read-divide-write loop around the mean store
// reset: synchronous rst clears queue, pipeline valids, frame counter and
//   sets pixel_count to 65536; the mean store is not cleared
`default_nettype none

module per_pixel_running_mean (
  input  wire logic          clk,
  input  wire logic          rst,
  // pixel_count register
  input  wire logic          cfg_we,
  input  wire logic [16:0]   cfg_data,
  // input items
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  input  wire logic [47:0]   s_axis_tdata,   // pixel_index, red_in, green_in, blue_in, alpha_in
  // result items
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  output logic [63:0]        m_axis_tdata,   // pixel_index_out, mean_red, mean_green,
                                             // mean_blue, mean_alpha, frames_averaged
  output logic               m_axis_tlast,   // frame_complete
  output logic               m_axis_tuser    // index_error
);

  logic           push;
  ppm_pkg::item_t push_item;
  logic           q_full;
  logic           pop;
  logic           head_valid;
  ppm_pkg::item_t head_item;

  // front: index check, frame counter, n and first-frame flag per item
  ppm_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_full        (q_full),
    .push          (push),
    .push_item     (push_item)
  );

  // decouples the stream input from back-side stalls
  ppm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .pop        (pop),
    .full       (q_full),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  // back: store read, 8-stage divide, mean update and write, result register
  ppm_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head_valid    (head_valid),
    .head_item     (head_item),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

`default_nettype wire

FILE: hdl/ppm_checker.sv
// port checker for the per-pixel running mean top level, with its bind
// depends on per_pixel_running_mean_defines.svh
`default_nettype none
`include "per_pixel_running_mean_defines.svh"

module ppm_port_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [63:0] m_axis_tdata,
  input wire logic        m_axis_tlast,
  input wire logic        m_axis_tuser
);

  // a rejected item carries no means and never ends a frame
  `PPM_ASSERT_NOW(err_zero, m_axis_tvalid && m_axis_tuser,
    m_axis_tdata[63:16] == 48'd0 && !m_axis_tlast, "error item with payload")
  // a good item always counts at least one frame
  `PPM_ASSERT_NOW(frames_nz, m_axis_tvalid && !m_axis_tuser,
    m_axis_tdata[63:48] != 16'd0, "zero frame count")
  // a stalled item holds
  `PPM_ASSERT_NEXT(out_hold, m_axis_tvalid && !m_axis_tready,
    m_axis_tvalid && $stable(m_axis_tdata), "stalled item changed")
  // nothing comes out right after reset
  `PPM_ASSERT_RST(rst_empty, rst, !m_axis_tvalid, "item after reset")

endmodule

bind per_pixel_running_mean ppm_port_checker u_ppm_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

FILE: sim/ppm_checker.sv
`timescale 1ns / 1ps
// checker for the per-pixel running mean block: watches the item channels,
// predicts each result and compares it; depends on ppm_pkg
`default_nettype none

module ppm_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [16:0] cfg_data,
  input  wire logic        s_axis_tvalid,
  input  wire logic        s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,
  input  wire logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  input  wire logic [63:0] m_axis_tdata,
  input  wire logic        m_axis_tlast,
  input  wire logic        m_axis_tuser,
  output int               errors,
  output int               pending
);

  typedef struct {
    logic [15:0] idx;
    logic [7:0]  mean [ppm_pkg::NUM_CH];
    logic [15:0] frames;
    logic        done;
    logic        err;
  } mean_result_t;

  mean_result_t                  want_q [$];
  logic [ppm_pkg::CFG_W-1:0]     pix_count;
  logic [15:0]                   frame_cnt;
  logic [ppm_pkg::MEAN_W-1:0]    acc [0:65535][ppm_pkg::NUM_CH];

  assign pending = want_q.size();

  task automatic report(input string what, input int got, input int exp);
    $display("mismatch at %0t: %s got %0h expected %0h", $time, what, got, exp);
    errors++;
  endtask

  function automatic mean_result_t advance_mean(input logic [47:0] d);
    mean_result_t r;
    int lim, n, diff;
    r.idx = d[15:0];
    r.frames = '0; r.done = 1'b0; r.err = 1'b0;
    foreach (r.mean[c]) r.mean[c] = '0;
    lim = (pix_count < ppm_pkg::MAX_PIXELS) ? int'(pix_count) : int'(ppm_pkg::MAX_PIXELS);
    if (int'(r.idx) >= lim) begin
      r.err = 1'b1;
      return r;
    end
    n = int'(frame_cnt) + 1;
    if (n > int'(ppm_pkg::COUNT_MAX)) n = int'(ppm_pkg::COUNT_MAX);
    for (int c = 0; c < ppm_pkg::NUM_CH; c++) begin
      if (frame_cnt == 0) begin
        acc[r.idx][c] = {d[16 + 8*c +: 8], 8'h00};
      end else begin
        diff = int'({d[16 + 8*c +: 8], 8'h00}) - int'(acc[r.idx][c]);
        acc[r.idx][c] = ppm_pkg::MEAN_W'(int'(acc[r.idx][c]) + diff / n);
      end
      r.mean[c] = acc[r.idx][c][ppm_pkg::MEAN_W-1 -: ppm_pkg::CH_W];
    end
    r.frames = 16'(n);
    if (int'(r.idx) == lim - 1) begin
      r.done = 1'b1;
      if (frame_cnt != ppm_pkg::COUNT_MAX) frame_cnt = frame_cnt + 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    mean_result_t w;
    if (rst) begin
      pix_count = ppm_pkg::MAX_PIXELS;
      frame_cnt = '0;
      want_q.delete();
    end else begin
      if (cfg_we) pix_count = cfg_data;
      if (m_axis_tvalid && m_axis_tready) begin
        if (want_q.size() == 0) begin
          report("unexpected item", int'(m_axis_tdata[15:0]), 0);
        end else begin
          w = want_q.pop_front();
          if (m_axis_tdata[15:0] != w.idx)
            report("index", int'(m_axis_tdata[15:0]), int'(w.idx));
          for (int c = 0; c < ppm_pkg::NUM_CH; c++)
            if (m_axis_tdata[16 + 8*c +: 8] != w.mean[c])
              report("mean", int'(m_axis_tdata[16 + 8*c +: 8]), int'(w.mean[c]));
          if (m_axis_tdata[63:48] != w.frames)
            report("frames", int'(m_axis_tdata[63:48]), int'(w.frames));
          if (m_axis_tlast != w.done)
            report("frame_complete", int'(m_axis_tlast), int'(w.done));
          if (m_axis_tuser != w.err)
            report("index_error", int'(m_axis_tuser), int'(w.err));
        end
      end
      if (s_axis_tvalid && s_axis_tready) want_q.push_back(advance_mean(s_axis_tdata));
    end
  end

  initial errors = 0;
endmodule

`default_nettype wire

FILE: sim/tb.sv
`timescale 1ns / 1ps
// testbench top for the per-pixel running mean block: drives pixel items and
// the pixel_count register, verdict from ppm_checker
`default_nettype none

module tb;

  localparam int CYCLE_LIMIT = 4000000;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [16:0] cfg_data;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;   // pixel_index, red_in, green_in, blue_in, alpha_in
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;   // pixel_index_out, mean_red, mean_green, mean_blue,
                               // mean_alpha, frames_averaged
  logic        m_axis_tlast;   // frame_complete
  logic        m_axis_tuser;   // index_error

  int errors, pending, cycles;
  int idle_pct;          // chance in a hundred that either side idles
  bit hold_req;          // asks the receiver for one long hold-off
  int hold_left;
  int cur_count;         // pixel_count as last written

  per_pixel_running_mean dut (
    .clk, .rst, .cfg_we, .cfg_data,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser
  );

  ppm_checker chk (
    .clk, .rst, .cfg_we, .cfg_data,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast, .m_axis_tuser,
    .errors, .pending
  );

  // 4 ns clock
  always begin
    clk = 1'b1; #2;
    clk = 1'b0; #2;
  end

  // watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // receiver: random back-pressure, plus one long hold-off on request so the
  // block fills up and stalls its input side
  initial begin
    m_axis_tready = 1'b0;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // offer one item, called at a falling edge, returns at a falling edge;
  // valid is only lowered when the sender idles, never lowered and raised
  // within one step
  task automatic push_pixel(input logic [15:0] idx, input logic [31:0] rgba);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {rgba, idx};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
  endtask

  // wait for every result, then write
  task automatic set_count(input int value);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= 17'(value);
    cur_count = value;
    @(negedge clk);
    cfg_we   <= 1'b0;
  endtask

  initial begin
    int pick, phase_counts [5];
    logic [15:0] idx;
    phase_counts = '{256, 1, 17, 100, 255};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    idle_pct = 34;
    hold_req = 1'b0;
    cur_count = 65536;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // first frame at the reset count: loads every pixel used later but 65535,
    // with the sample extremes on pixels 0 and 255
    push_pixel(16'd0, 32'h0000_0000);
    for (int i = 1; i < 255; i++) push_pixel(16'(i), $urandom);
    push_pixel(16'd255, 32'hFFFF_FFFF);
    push_pixel(16'd40000, $urandom);
    push_pixel(16'd65534, 32'hFF00_FF00);

    // zero count: every index is out of range
    set_count(0);
    push_pixel(16'd0, $urandom);
    push_pixel(16'hFFFF, $urandom);
    // count beyond the index range: the top index still closes the frame
    set_count(131071);
    push_pixel(16'hFFFF, 32'h00FF_00FF);
    push_pixel(16'd65534, 32'h0000_0000);
    push_pixel(16'hFFFF, 32'hFFFF_FFFF);
    // largest in-range count, later frame
    set_count(65536);
    push_pixel(16'd65534, 32'hFFFF_FFFF);
    push_pixel(16'hFFFF, 32'h0000_0000);

    // random phases over small frames, pixels already loaded
    for (int p = 0; p < 5; p++) begin
      set_count(phase_counts[p]);
      for (int i = 0; i < 50; i++) begin
        // no idling at all for a stretch of the third phase
        idle_pct = (p == 2 && i < 40) ? 0 : 34;
        if (p == 0 && i == 20) hold_req = 1'b1;
        pick = $urandom_range(99);
        if (pick < 15) idx = 16'($urandom_range(65535));
        else if (pick < 35) idx = 16'(cur_count - 1);
        else idx = 16'($urandom_range(cur_count - 1));
        push_pixel(idx, $urandom);
      end
    end

    // one pixel per frame, back to back on the same pixel
    set_count(1);
    idle_pct = 0;
    for (int i = 0; i < 20; i++) push_pixel(16'd0, $urandom);
    idle_pct = 34;
    push_pixel(16'd1, $urandom);
    push_pixel(16'd0, 32'hFFFF_FFFF);
    push_pixel(16'd0, 32'h0000_0000);

    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

`default_nettype wire
